@@ rtl/mct_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mct_pkg
// shared types and constants for the mouse cursor tracker
// ----------------------------------------------------------------------------
package mct_pkg;

	localparam int unsigned PosW  = 10;
	localparam int unsigned DispW = 8;
	localparam int unsigned BtnW  = 8;
	localparam int unsigned DivW  = 4;
	localparam int unsigned ExpW  = 2;
	localparam int unsigned CfgIdxW = 2;

	localparam int unsigned MiddleBit = 2;

	localparam logic [PosW-1:0] XLimitRst = 10'd623;
	localparam logic [PosW-1:0] YFloorRst = 10'd16;
	localparam logic [PosW-1:0] YLimitRst = 10'd478;
	localparam logic [PosW-1:0] PosXRst   = 10'd0;
	localparam logic [PosW-1:0] PosYRst   = 10'd16;

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		CFG_X_LIMIT = 2'd0,
		CFG_Y_FLOOR = 2'd1,
		CFG_Y_LIMIT = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic signed [DispW-1:0] x_disp;
		logic signed [DispW-1:0] y_disp;
		logic [BtnW-1:0]         buttons;
	} report_t;

	typedef struct packed {
		logic [PosW-1:0] cursor_x;
		logic [PosW-1:0] cursor_y;
		logic [BtnW-1:0] button_status;
		logic [DivW-1:0] divisor;
	} cursor_t;

endpackage
`default_nettype wire

@@ rtl/mct_axis.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mct_axis
// one axis: scale displacement toward zero, add to position, clamp
// ----------------------------------------------------------------------------
module mct_axis (
	input  wire logic [mct_pkg::PosW-1:0]         pos,
	input  wire logic signed [mct_pkg::DispW-1:0] disp,
	input  wire logic [mct_pkg::ExpW-1:0]         sense_exp,
	input  wire logic [mct_pkg::PosW-1:0]         lo,
	input  wire logic [mct_pkg::PosW-1:0]         hi,
	output logic [mct_pkg::PosW-1:0]              pos_next
);
	import mct_pkg::*;

	logic [DispW:0]          round_mask;
	logic signed [DispW:0]   biased;
	logic signed [DispW:0]   quot;
	logic signed [PosW+1:0]  sum;
	logic signed [PosW+1:0]  lo_ext;
	logic signed [PosW+1:0]  hi_ext;

	always_comb begin
		// negative values get 2^e-1 added so the arithmetic shift truncates toward zero
		round_mask = (DispW+1)'((9'd1 << sense_exp) - 9'd1);
		biased     = {disp[DispW-1], disp};
		if (disp[DispW-1]) begin
			biased = biased + $signed(round_mask);
		end
		quot   = biased >>> sense_exp;
		sum    = $signed({2'b00, pos}) + (PosW+2)'(quot);
		lo_ext = $signed({2'b00, lo});
		hi_ext = $signed({2'b00, hi});
		// floor test first, then ceiling
		priority if (sum < lo_ext) begin
			pos_next = lo;
		end else if (sum > hi_ext) begin
			pos_next = hi;
		end else begin
			pos_next = sum[PosW-1:0];
		end
	end

endmodule
`default_nettype wire

@@ rtl/mouse_cursor_tracker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mouse_cursor_tracker
// turns mouse reports into a clamped cursor position, button status and divisor
// ----------------------------------------------------------------------------
// a request accepted into the input register passes through shift/add/clamp into the
//   result register, from which it can be taken
// throughput: one request per cycle while the result side is not stalled; input
//   register, one pass of shift/add/clamp, result register
// the result register frees the input side while a result waits to be taken
// reset: cursor at (0,16), divisor 1, status 0, limits 623 / 16 / 478
module mouse_cursor_tracker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// request channel
	input  wire logic                          report_valid,
	output logic                               report_stall,
	input  wire mct_pkg::report_t              report,
	// result channel
	output logic                               cursor_valid,
	input  wire logic                          cursor_stall,
	output mct_pkg::cursor_t                   cursor,
	// configuration write channel
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [mct_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [mct_pkg::PosW-1:0]      cfg_data
);
	import mct_pkg::*;

	// input register
	logic    valid_s1;
	report_t report_s1;

	// result register
	logic    cursor_valid_q;
	cursor_t cursor_q;

	// tracker state
	logic [PosW-1:0] pos_x_q;
	logic [PosW-1:0] pos_y_q;
	logic [ExpW-1:0] sense_exp_q;
	logic            middle_held_q;
	logic [BtnW-1:0] status_hold_q;

	// configuration
	logic [PosW-1:0] x_limit_q;
	logic [PosW-1:0] y_floor_q;
	logic [PosW-1:0] y_limit_q;

	logic            advance;
	logic            accept;
	logic [PosW-1:0] pos_x_next;
	logic [PosW-1:0] pos_y_next;
	logic [ExpW-1:0] sense_exp_next;
	logic            middle_held_next;
	logic [BtnW-1:0] status_hold_next;
	logic            middle_down;

	// the request in the input register moves on when the result slot is free
	// or is emptied in this same cycle
	assign advance      = valid_s1 && (!cursor_valid_q || !cursor_stall);
	assign report_stall = valid_s1 && !advance;
	assign accept       = report_valid && !report_stall;
	assign cfg_ready    = 1'b1;

	assign cursor_valid = cursor_valid_q;
	assign cursor       = cursor_q;

	// x is clamped to 0..x_limit, y to y_floor..y_limit; both use the divisor
	// in force before this request
	mct_axis u_axis_x (
		.pos       (pos_x_q),
		.disp      (report_s1.x_disp),
		.sense_exp (sense_exp_q),
		.lo        ('0),
		.hi        (x_limit_q),
		.pos_next  (pos_x_next)
	);

	mct_axis u_axis_y (
		.pos       (pos_y_q),
		.disp      (report_s1.y_disp),
		.sense_exp (sense_exp_q),
		.lo        (y_floor_q),
		.hi        (y_limit_q),
		.pos_next  (pos_y_next)
	);

	// middle button: a fresh press bumps the divisor exponent (wraps 8 -> 1),
	// and while it is down the status byte is frozen
	always_comb begin
		middle_down      = report_s1.buttons[MiddleBit];
		sense_exp_next   = sense_exp_q;
		middle_held_next = middle_held_q;
		status_hold_next = status_hold_q;
		if (middle_down) begin
			if (!middle_held_q) begin
				sense_exp_next = sense_exp_q + 1'b1;
			end
			middle_held_next = 1'b1;
		end else begin
			middle_held_next = 1'b0;
			status_hold_next = report_s1.buttons;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!report_stall) begin
			valid_s1 <= report_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			report_s1 <= report;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_valid_q <= 1'b0;
		end else if (advance) begin
			cursor_valid_q <= 1'b1;
		end else if (!cursor_stall) begin
			cursor_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cursor_q.cursor_x      <= pos_x_next;
			cursor_q.cursor_y      <= pos_y_next;
			cursor_q.button_status <= status_hold_next;
			cursor_q.divisor       <= DivW'(4'd1 << sense_exp_next);
		end
	end

	// tracker state updates once per request, as it leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q       <= PosXRst;
			pos_y_q       <= PosYRst;
			sense_exp_q   <= '0;
			middle_held_q <= 1'b0;
			status_hold_q <= '0;
		end else if (advance) begin
			pos_x_q       <= pos_x_next;
			pos_y_q       <= pos_y_next;
			sense_exp_q   <= sense_exp_next;
			middle_held_q <= middle_held_next;
			status_hold_q <= status_hold_next;
		end
	end

	// configuration registers; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_limit_q <= XLimitRst;
			y_floor_q <= YFloorRst;
			y_limit_q <= YLimitRst;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_X_LIMIT: x_limit_q <= cfg_data;
				CFG_Y_FLOOR: y_floor_q <= cfg_data;
				CFG_Y_LIMIT: y_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// divisor is always a single power of two
	a_divisor_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_valid_q |-> $onehot(cursor_q.divisor))
		else $error("divisor not a power of two");

	// published position matches the held position
	a_pos_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (cursor_q.cursor_x == pos_x_q) && (cursor_q.cursor_y == pos_y_q))
		else $error("result position differs from held position");

	// a request held in the input register does not change
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1 && $stable(report_s1))
		else $error("stalled request lost or changed");

	// a fresh middle press steps the exponent by one
	a_press_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(middle_held_q) |-> (sense_exp_q == ExpW'($past(sense_exp_q) + 1'b1)))
		else $error("exponent did not step on middle press");

	// stall only while a request sits in the input register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		report_stall |-> valid_s1)
		else $error("stall without a held request");

endmodule
`default_nettype wire
